>>> src/gtg_pkg.sv
package gtg_pkg;

  // Datapath widths
  localparam int POS_W   = 32;
  localparam int DIFF_W  = 33;   // target minus pose, kept exact
  localparam int XY_W    = 36;   // CORDIC x/y, covers pre-rotation and gain
  localparam int Z_W     = 34;   // Q2.30 angle accumulator with headroom
  localparam int HEAD_W  = 16;
  localparam int ERR_W   = 18;   // heading error before and after wrapping
  localparam int WRAP_W  = 22;   // offset error used by the modulo reduction
  localparam int TOL_W   = 20;
  localparam int RATE_W  = 15;
  localparam int ANG_W   = 16;

  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sh06487ED51;
  localparam longint PI_Q30 = 64'sd3373259426;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TARGET_X    = 3'd0,
    REG_TARGET_Y    = 3'd1,
    REG_TOLERANCE   = 3'd2,
    REG_COARSE_BAND = 3'd3,
    REG_FINE_BAND   = 3'd4,
    REG_COARSE_RATE = 3'd5,
    REG_FINE_RATE   = 3'd6,
    REG_CRUISE      = 3'd7
  } reg_index_t;

  // One item inside the CORDIC pipeline
  typedef struct packed {
    logic                     valid;
    logic                     arrived;
    logic                     zero;
    logic signed [HEAD_W-1:0] head;
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [Z_W-1:0]    z;
  } cordic_t;

  // atan(2^-i) truncated to Q2.30
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] r;
    case (i)
      0:       r = 32'h3243F6A8;
      1:       r = 32'h1DAC6705;
      2:       r = 32'h0FADBAFC;
      3:       r = 32'h07F56EA6;
      4:       r = 32'h03FEAB76;
      5:       r = 32'h01FFD55B;
      6:       r = 32'h00FFFAAA;
      7:       r = 32'h007FFF55;
      8:       r = 32'h003FFFEA;
      9:       r = 32'h001FFFFD;
      10:      r = 32'h000FFFFF;
      11:      r = 32'h0007FFFF;
      12:      r = 32'h0003FFFF;
      13:      r = 32'h0001FFFF;
      14:      r = 32'h0000FFFF;
      15:      r = 32'h00007FFF;
      16:      r = 32'h00003FFF;
      17:      r = 32'h00001FFF;
      18:      r = 32'h00000FFF;
      19:      r = 32'h000007FF;
      20:      r = 32'h000003FF;
      21:      r = 32'h000001FF;
      22:      r = 32'h000000FF;
      23:      r = 32'h0000007F;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> src/gtg_cordic_stage.sv
module gtg_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  gtg_pkg::cordic_t  d,
  output gtg_pkg::cordic_t  q
);

  logic signed [gtg_pkg::XY_W-1:0] xs;
  logic signed [gtg_pkg::XY_W-1:0] ys;
  logic signed [gtg_pkg::Z_W-1:0]  angle;
  gtg_pkg::cordic_t                nxt;

  // Rotate toward the x axis by atan(2^-STEP)
  always_comb begin
    xs    = d.x >>> STEP;
    ys    = d.y >>> STEP;
    angle = $signed({2'b00, gtg_pkg::atan_q30(STEP)});
    nxt   = d;
    if (!d.y[gtg_pkg::XY_W-1]) begin
      nxt.x = d.x + ys;
      nxt.y = d.y - xs;
      nxt.z = d.z + angle;
    end else begin
      nxt.x = d.x - ys;
      nxt.y = d.y + xs;
      nxt.z = d.z - angle;
    end
  end

  // Clear valid under reset; advance everything when enabled
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= nxt.valid;
    end
    if (en) begin
      q.arrived <= nxt.arrived;
      q.zero    <= nxt.zero;
      q.head    <= nxt.head;
      q.x       <= nxt.x;
      q.y       <= nxt.y;
      q.z       <= nxt.z;
    end
  end

endmodule

>>> src/go_to_goal_steering.sv
// Channel  Direction  Handshake                Payload
// pose     in         pose_valid / pose_ready  pose_x, pose_y, heading
// cmd      out        cmd_valid / cmd_ready    linear_speed, angular_rate, arrived
// cfg      in         cfg_write (no wait)      cfg_index, cfg_data
//
// One pose enters per cycle while the skid register is empty; its command is
// registered through difference, pre-rotation, one register per CORDIC iteration,
// rounding, wrapping and classification.
// rst clears all valid bits and loads the register defaults.
// A command not taken moves into a one-entry skid register; the pipeline then
// freezes until the skid register drains, so nothing is lost or repeated.
module go_to_goal_steering #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pose_valid,
  output logic                               pose_ready,
  input  logic signed [gtg_pkg::POS_W-1:0]   pose_x,
  input  logic signed [gtg_pkg::POS_W-1:0]   pose_y,
  input  logic signed [gtg_pkg::HEAD_W-1:0]  heading,
  output logic                               cmd_valid,
  input  logic                               cmd_ready,
  output logic        [gtg_pkg::RATE_W-1:0]  linear_speed,
  output logic signed [gtg_pkg::ANG_W-1:0]   angular_rate,
  output logic                               arrived,
  input  logic                               cfg_write,
  input  logic        [2:0]                  cfg_index,
  input  logic        [gtg_pkg::POS_W-1:0]   cfg_data
);

  localparam int RoundShift = 30 - ANGLE_FRAC_BITS;
  localparam longint PiVal = (gtg_pkg::PI_Q30 + (longint'(1) <<< (RoundShift - 1)))
                             >>> RoundShift;
  localparam longint TwoPiVal = 2 * PiVal;
  // Highest multiple 2pi*2^WrapK must exceed any raw error magnitude (< 2^17)
  localparam int WrapK = $clog2((longint'(1) <<< 17) / TwoPiVal + 1);
  localparam logic signed [gtg_pkg::WRAP_W-1:0] PiW    = gtg_pkg::WRAP_W'(PiVal);
  localparam logic signed [gtg_pkg::WRAP_W-1:0] TwoPiW = gtg_pkg::WRAP_W'(TwoPiVal);
  localparam logic signed [gtg_pkg::WRAP_W-1:0] WrapOfs =
    gtg_pkg::WRAP_W'(PiVal - 1 + (TwoPiVal <<< WrapK));
  localparam logic signed [gtg_pkg::Z_W-1:0] RoundHalf =
    gtg_pkg::Z_W'(longint'(1) <<< (RoundShift - 1));

  // Configuration registers
  logic signed [gtg_pkg::POS_W-1:0]  target_x;
  logic signed [gtg_pkg::POS_W-1:0]  target_y;
  logic        [gtg_pkg::TOL_W-1:0]  arrive_tolerance;
  logic        [gtg_pkg::RATE_W-1:0] coarse_band;
  logic        [gtg_pkg::RATE_W-1:0] fine_band;
  logic        [gtg_pkg::RATE_W-1:0] coarse_turn_rate;
  logic        [gtg_pkg::RATE_W-1:0] fine_turn_rate;
  logic        [gtg_pkg::RATE_W-1:0] cruise_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x         <= '0;
      target_y         <= '0;
      arrive_tolerance <= 20'd6554;
      coarse_band      <= 15'd2458;
      fine_band        <= 15'd819;
      coarse_turn_rate <= 15'd2458;
      fine_turn_rate   <= 15'd819;
      cruise_speed     <= 15'd4096;
    end else if (cfg_write) begin
      case (cfg_index)
        gtg_pkg::REG_TARGET_X:    target_x         <= cfg_data;
        gtg_pkg::REG_TARGET_Y:    target_y         <= cfg_data;
        gtg_pkg::REG_TOLERANCE:   arrive_tolerance <= cfg_data[gtg_pkg::TOL_W-1:0];
        gtg_pkg::REG_COARSE_BAND: coarse_band      <= cfg_data[gtg_pkg::RATE_W-1:0];
        gtg_pkg::REG_FINE_BAND:   fine_band        <= cfg_data[gtg_pkg::RATE_W-1:0];
        gtg_pkg::REG_COARSE_RATE: coarse_turn_rate <= cfg_data[gtg_pkg::RATE_W-1:0];
        gtg_pkg::REG_FINE_RATE:   fine_turn_rate   <= cfg_data[gtg_pkg::RATE_W-1:0];
        gtg_pkg::REG_CRUISE:      cruise_speed     <= cfg_data[gtg_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline enable: the whole pipe moves while the skid register is empty
  logic skid_full;
  logic en;

  assign en         = !skid_full;
  assign pose_ready = en;

  // Stage 0: position errors
  logic                               v0;
  logic signed [gtg_pkg::DIFF_W-1:0]  dx0;
  logic signed [gtg_pkg::DIFF_W-1:0]  dy0;
  logic signed [gtg_pkg::HEAD_W-1:0]  head0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= pose_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx0   <= {target_x[gtg_pkg::POS_W-1], target_x} - {pose_x[gtg_pkg::POS_W-1], pose_x};
      dy0   <= {target_y[gtg_pkg::POS_W-1], target_y} - {pose_y[gtg_pkg::POS_W-1], pose_y};
      head0 <= heading;
    end
  end

  // Stage 1: arrival test and pre-rotation into the right half plane
  logic        [gtg_pkg::DIFF_W-1:0] adx;
  logic        [gtg_pkg::DIFF_W-1:0] ady;
  logic signed [gtg_pkg::XY_W-1:0]   dxe;
  logic signed [gtg_pkg::XY_W-1:0]   dye;
  gtg_pkg::cordic_t                  pre;
  gtg_pkg::cordic_t                  c1;

  always_comb begin
    adx = dx0[gtg_pkg::DIFF_W-1] ? (~dx0 + 33'd1) : dx0;
    ady = dy0[gtg_pkg::DIFF_W-1] ? (~dy0 + 33'd1) : dy0;
    dxe = gtg_pkg::XY_W'(dx0);
    dye = gtg_pkg::XY_W'(dy0);
    pre.valid   = v0;
    pre.arrived = (adx < {13'd0, arrive_tolerance}) && (ady < {13'd0, arrive_tolerance});
    pre.zero    = (dx0 == '0) && (dy0 == '0);
    pre.head    = head0;
    pre.x       = dxe;
    pre.y       = dye;
    pre.z       = '0;
    if (dx0[gtg_pkg::DIFF_W-1]) begin
      if (!dy0[gtg_pkg::DIFF_W-1]) begin
        pre.x = dye;
        pre.y = -dxe;
        pre.z = gtg_pkg::HALF_PI_Q30;
      end else begin
        pre.x = -dye;
        pre.y = dxe;
        pre.z = -gtg_pkg::HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.valid <= 1'b0;
    end else if (en) begin
      c1.valid <= pre.valid;
    end
    if (en) begin
      c1.arrived <= pre.arrived;
      c1.zero    <= pre.zero;
      c1.head    <= pre.head;
      c1.x       <= pre.x;
      c1.y       <= pre.y;
      c1.z       <= pre.z;
    end
  end

  // CORDIC iterations, one register stage each
  gtg_pkg::cordic_t cs [CORDIC_STEPS+1];

  assign cs[0] = c1;

  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
    gtg_cordic_stage #(
      .STEP (gi)
    ) u_stage (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (cs[gi]),
      .q   (cs[gi+1])
    );
  end

  // Rounding stage: bearing to angle format, minus heading
  gtg_pkg::cordic_t                  cl;
  logic signed [gtg_pkg::Z_W-1:0]    zsum;
  logic signed [gtg_pkg::Z_W-1:0]    zr;
  logic signed [gtg_pkg::ERR_W-1:0]  err_raw;
  logic                              vr;
  logic                              arr_r;
  logic signed [gtg_pkg::ERR_W-1:0]  err_r;

  assign cl = cs[CORDIC_STEPS];

  always_comb begin
    zsum    = (cl.zero ? '0 : cl.z) + RoundHalf;
    zr      = zsum >>> RoundShift;
    err_raw = zr[gtg_pkg::ERR_W-1:0] - {{2{cl.head[gtg_pkg::HEAD_W-1]}}, cl.head};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (en) begin
      vr <= cl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arr_r <= cl.arrived;
      err_r <= err_raw;
    end
  end

  // Wrapping stage: reduce error into (-pi, pi] by binary modulo
  logic signed [gtg_pkg::WRAP_W-1:0] wmod;
  logic signed [gtg_pkg::WRAP_W-1:0] wstep;
  logic signed [gtg_pkg::WRAP_W-1:0] wres;
  logic                              vw;
  logic                              arr_w;
  logic signed [gtg_pkg::ERR_W-1:0]  err_w;

  always_comb begin
    wmod = gtg_pkg::WRAP_W'(err_r) + WrapOfs;
    for (int j = WrapK; j >= 0; j--) begin
      wstep = TwoPiW <<< j;
      if (wmod >= wstep) begin
        wmod = wmod - wstep;
      end
    end
    wres = wmod - (PiW - 22'sd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vw <= 1'b0;
    end else if (en) begin
      vw <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arr_w <= arr_r;
      err_w <= wres[gtg_pkg::ERR_W-1:0];
    end
  end

  // Classification stage: pick turn or drive command
  logic signed [gtg_pkg::ERR_W-1:0]  cb;
  logic signed [gtg_pkg::ERR_W-1:0]  fb;
  logic        [gtg_pkg::RATE_W-1:0] lin_c;
  logic signed [gtg_pkg::ANG_W-1:0]  ang_c;
  logic                              vo;
  logic        [gtg_pkg::RATE_W-1:0] lin_o;
  logic signed [gtg_pkg::ANG_W-1:0]  ang_o;
  logic                              arr_o;

  always_comb begin
    cb    = $signed({3'b000, coarse_band});
    fb    = $signed({3'b000, fine_band});
    lin_c = '0;
    ang_c = '0;
    if (arr_w) begin
      lin_c = '0;
      ang_c = '0;
    end else if (err_w > cb) begin
      ang_c = $signed({1'b0, coarse_turn_rate});
    end else if (err_w < -cb) begin
      ang_c = -$signed({1'b0, coarse_turn_rate});
    end else if (err_w > fb) begin
      ang_c = $signed({1'b0, fine_turn_rate});
    end else if (err_w < -fb) begin
      ang_c = -$signed({1'b0, fine_turn_rate});
    end else begin
      lin_c = cruise_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= vw;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin_o <= lin_c;
      ang_o <= ang_c;
      arr_o <= arr_w;
    end
  end

  // Skid register: catch the last stage's item when the output stalls
  logic        [gtg_pkg::RATE_W-1:0] skid_lin;
  logic signed [gtg_pkg::ANG_W-1:0]  skid_ang;
  logic                              skid_arr;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (cmd_ready) begin
        skid_full <= 1'b0;
      end
    end else if (vo && !cmd_ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_lin <= lin_o;
      skid_ang <= ang_o;
      skid_arr <= arr_o;
    end
  end

  assign cmd_valid    = skid_full || vo;
  assign linear_speed = skid_full ? skid_lin : lin_o;
  assign angular_rate = skid_full ? skid_ang : ang_o;
  assign arrived      = skid_full ? skid_arr : arr_o;

  // Checks
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    pose_valid && pose_ready |=> v0)
    else $error("accepted item did not enter stage 0");

  a_skid_blocks: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> !pose_ready)
    else $error("input accepted while skid register is full");

  a_wrap_range: assert property (@(posedge clk) disable iff (rst)
    vw |-> (err_w > -gtg_pkg::ERR_W'(PiVal)) && (err_w <= gtg_pkg::ERR_W'(PiVal)))
    else $error("wrapped heading error outside (-pi, pi]");

  a_arrived_zero: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && arrived |-> (linear_speed == '0) && (angular_rate == '0))
    else $error("arrival with nonzero command");

  a_one_motion: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> (linear_speed == '0) || (angular_rate == '0))
    else $error("drive and turn commanded together");

endmodule
